// ----- rtl/polygon_zone_edge_fade_unit_assert.svh -----
// assertion macros for the polygon zone edge fade unit
`ifndef POLYGON_ZONE_EDGE_FADE_UNIT_ASSERT_SVH
`define POLYGON_ZONE_EDGE_FADE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define PZEF_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("pzef assertion failed");
`define PZEF_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("pzef assertion failed");
`else
`define PZEF_ASSERT_IMPLY(lbl, ck, rs, ante, cons)
`define PZEF_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

// ----- rtl/pzef_pkg.sv -----
// shared types and constants of the polygon zone edge fade unit
package pzef_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int COORD_W    = 32;
  localparam int COUNT_W    = 7;
  localparam int LM_A_W     = 130;
  localparam int LM_B_W     = 66;
  localparam int LM_P_W     = LM_A_W + LM_B_W;

  localparam logic [16:0] WEIGHT_ONE = 17'd65536;

  typedef enum logic [1:0] {
    REG_Z_MIN       = 2'd0,
    REG_Z_MAX       = 2'd1,
    REG_EDGE_FADE   = 2'd2,
    REG_POINT_COUNT = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef struct packed {
    logic                      func;
    logic [5:0]                vertex_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } item_t;

  typedef struct packed {
    logic [16:0] weight;
    logic        inside_res;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [LM_A_W-1:0] a;
    logic [LM_B_W-1:0] b;
  } lm_req_t;

  typedef struct packed {
    logic              done;
    logic [LM_P_W-1:0] p;
  } lm_rsp_t;

endpackage

// ----- rtl/polygon_zone_edge_fade_unit.sv -----
// top level of the polygon zone edge fade unit
//
// item channel (item_valid, item_stall, item): a word with func load writes a
// vertex into the store; a word with func query returns one result word on the
// result channel (result_valid, result_stall, result). item_stall is high in
// reset and while a query is being worked on; one query at a time. configuration:
// cfg_wr_en, cfg_index, cfg_data write a register at once. a query outside the
// height band goes straight to the output register; otherwise, per edge, the
// shared multiplier forms the edge products, then up to three serial products
// follow; a binary search for the weight comes last, each of its steps using
// two serial products. the serial multiplier retires one multiplier bit per
// cycle. a finished result waits in the output register while result_stall is
// high; a new item is taken meanwhile, and its result waits until the old one
// goes. reset clears state, empties the output register and loads the register
// defaults; the vertex store holds nothing defined until written.
`include "polygon_zone_edge_fade_unit_assert.svh"
module polygon_zone_edge_fade_unit import pzef_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_RD_A, S_LAT_A, S_RD_B, S_LAT_B, S_MUL, S_DECIDE, S_SQ_W,
    S_CMP, S_CMP1_W, S_CMP2_W, S_NEXT, S_WS_LOOP, S_WS_MUL, S_WS_SQ,
    S_WS_SQ_W, S_WS_D_W, S_FIN
  } state_t;

  state_t state;

  logic signed [31:0] z_min;
  logic signed [31:0] z_max;
  logic [30:0]        edge_fade;
  logic [COUNT_W-1:0] point_count;
  logic [COUNT_W-1:0] n_pts;

  logic signed [31:0] px, py, ax, ay, bx, by;
  logic signed [32:0] ex, ey, wx, wy, ux, uy;
  logic               cross_f;
  logic [COUNT_W-1:0] idx;
  logic [ADDR_W-1:0]  rd_addr;
  logic [31:0]        rd_x, rd_y;
  logic               accept, wr_en;

  logic [3:0]         mstep, pstep;
  logic               pvld;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [66:0] prod_x;
  logic signed [66:0] cr, d1, d2, sw, su, se, cr_mag;

  logic [LM_A_W-1:0]  num, best_num;
  logic [LM_B_W-1:0]  den, best_den;
  logic               have, in_poly;
  logic [LM_P_W-1:0]  t1;
  lm_req_t            lm_req;
  lm_rsp_t            lm_rsp;

  logic [16:0]        lo, hi, mid, weight;
  logic [17:0]        mid_sum;

  assign accept     = item_valid && !item_stall;
  assign item_stall = rst || (state != S_IDLE);
  assign wr_en      = accept && (item.func == FUNC_LOAD) && (item.vertex_index < MAX_POINTS);
  assign n_pts      = (point_count > MAX_POINTS) ? COUNT_W'(MAX_POINTS) : point_count;
  assign prod_x     = {prod[65], prod};
  assign cr_mag     = cr[66] ? -cr : cr;
  assign mid_sum    = {1'b0, lo} + {1'b0, hi} + 18'd1;

  pzef_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) vertex_x_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(ADDR_W'(item.vertex_index)),
    .wr_data(item.coord_x), .rd_addr(rd_addr), .rd_data(rd_x)
  );

  pzef_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) vertex_y_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(ADDR_W'(item.vertex_index)),
    .wr_data(item.coord_y), .rd_addr(rd_addr), .rd_data(rd_y)
  );

  pzef_lmul u_lmul (.clk(clk), .rst(rst), .req(lm_req), .rsp(lm_rsp));

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = ex;
    mul_b = ex;
    if (state == S_WS_MUL) begin
      mul_a = $signed({16'b0, mid});
      mul_b = $signed({2'b0, edge_fade});
    end else begin
      case (mstep)
        4'd0:    begin mul_a = ex; mul_b = wy; end
        4'd1:    begin mul_a = ey; mul_b = wx; end
        4'd2:    begin mul_a = ex; mul_b = wx; end
        4'd3:    begin mul_a = ey; mul_b = wy; end
        4'd4:    begin mul_a = ex; mul_b = ux; end
        4'd5:    begin mul_a = ey; mul_b = uy; end
        4'd6:    begin mul_a = wx; mul_b = wx; end
        4'd7:    begin mul_a = wy; mul_b = wy; end
        4'd8:    begin mul_a = ux; mul_b = ux; end
        4'd9:    begin mul_a = uy; mul_b = uy; end
        4'd10:   begin mul_a = ex; mul_b = ex; end
        4'd11:   begin mul_a = ey; mul_b = ey; end
        default: begin mul_a = ex; mul_b = ex; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      z_min       <= 32'sh8000_0000;
      z_max       <= 32'sh7fff_ffff;
      edge_fade   <= 31'd256;
      point_count <= 7'd3;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_Z_MIN:       z_min       <= cfg_data;
        REG_Z_MAX:       z_max       <= cfg_data;
        REG_EDGE_FADE:   edge_fade   <= cfg_data[30:0];
        REG_POINT_COUNT: point_count <= cfg_data[COUNT_W-1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      lm_req.start <= 1'b0;
      pvld         <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_FIN) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && item.func == FUNC_QUERY) begin
            px      <= item.coord_x;
            py      <= item.coord_y;
            in_poly <= 1'b0;
            have    <= 1'b0;
            idx     <= '0;
            if (item.coord_z >= z_min && item.coord_z <= z_max && n_pts != '0) begin
              rd_addr <= ADDR_W'(n_pts - COUNT_W'(1));
              state   <= S_RD_A;
            end else begin
              weight <= '0;
              state  <= S_FIN;
            end
          end
        end
        S_RD_A: state <= S_LAT_A;
        S_LAT_A: begin
          ax      <= rd_x;
          ay      <= rd_y;
          rd_addr <= '0;
          state   <= S_RD_B;
        end
        S_RD_B: state <= S_LAT_B;
        S_LAT_B: begin
          bx      <= rd_x;
          by      <= rd_y;
          ex      <= {rd_x[31], rd_x} - {ax[31], ax};
          ey      <= {rd_y[31], rd_y} - {ay[31], ay};
          wx      <= {px[31], px} - {ax[31], ax};
          wy      <= {py[31], py} - {ay[31], ay};
          ux      <= {px[31], px} - {rd_x[31], rd_x};
          uy      <= {py[31], py} - {rd_y[31], rd_y};
          cross_f <= (ay > py) != ($signed(rd_y) > py);
          mstep   <= '0;
          pvld    <= 1'b0;
          state   <= S_MUL;
        end
        S_MUL: begin
          if (mstep != 4'd12) begin
            mstep <= mstep + 4'd1;
            pstep <= mstep;
            pvld  <= 1'b1;
          end else begin
            pvld <= 1'b0;
          end
          if (pvld) begin
            case (pstep)
              4'd0:    cr <= prod_x;
              4'd1:    cr <= cr - prod_x;
              4'd2:    d1 <= prod_x;
              4'd3:    d1 <= d1 + prod_x;
              4'd4:    d2 <= prod_x;
              4'd5:    d2 <= d2 + prod_x;
              4'd6:    sw <= prod_x;
              4'd7:    sw <= sw + prod_x;
              4'd8:    su <= prod_x;
              4'd9:    su <= su + prod_x;
              4'd10:   se <= prod_x;
              default: se <= se + prod_x;
            endcase
            if (pstep == 4'd11) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (cross_f && ((ey > 0 && cr > 0) || (ey < 0 && cr < 0))) begin
            in_poly <= !in_poly;
          end
          if ((ex == 0 && ey == 0) || d1 <= 0) begin
            num   <= {63'b0, sw};
            den   <= LM_B_W'(1);
            state <= S_CMP;
          end else if (d2 >= 0) begin
            num   <= {63'b0, su};
            den   <= LM_B_W'(1);
            state <= S_CMP;
          end else begin
            den          <= se[65:0];
            lm_req.start <= 1'b1;
            lm_req.a     <= {64'b0, cr_mag[65:0]};
            lm_req.b     <= cr_mag[65:0];
            state        <= S_SQ_W;
          end
        end
        S_SQ_W: begin
          lm_req.start <= 1'b0;
          if (lm_rsp.done) begin
            num   <= lm_rsp.p[LM_A_W-1:0];
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (!have) begin
            best_num <= num;
            best_den <= den;
            have     <= 1'b1;
            state    <= S_NEXT;
          end else begin
            lm_req.start <= 1'b1;
            lm_req.a     <= num;
            lm_req.b     <= best_den;
            state        <= S_CMP1_W;
          end
        end
        S_CMP1_W: begin
          if (lm_rsp.done) begin
            t1           <= lm_rsp.p;
            lm_req.start <= 1'b1;
            lm_req.a     <= best_num;
            lm_req.b     <= den;
            state        <= S_CMP2_W;
          end else begin
            lm_req.start <= 1'b0;
          end
        end
        S_CMP2_W: begin
          lm_req.start <= 1'b0;
          if (lm_rsp.done) begin
            if (t1 < lm_rsp.p) begin
              best_num <= num;
              best_den <= den;
            end
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          ax  <= bx;
          ay  <= by;
          idx <= idx + COUNT_W'(1);
          if (idx + COUNT_W'(1) == n_pts) begin
            if (in_poly) begin
              lo    <= '0;
              hi    <= WEIGHT_ONE;
              state <= S_WS_LOOP;
            end else begin
              weight <= '0;
              state  <= S_FIN;
            end
          end else begin
            rd_addr <= ADDR_W'(idx + COUNT_W'(1));
            state   <= S_RD_B;
          end
        end
        S_WS_LOOP: begin
          if (lo < hi) begin
            mid   <= mid_sum[17:1];
            state <= S_WS_MUL;
          end else begin
            weight <= lo;
            state  <= S_FIN;
          end
        end
        S_WS_MUL: state <= S_WS_SQ;
        S_WS_SQ: begin
          lm_req.start <= 1'b1;
          lm_req.a     <= {82'b0, prod[47:0]};
          lm_req.b     <= {18'b0, prod[47:0]};
          state        <= S_WS_SQ_W;
        end
        S_WS_SQ_W: begin
          if (lm_rsp.done) begin
            lm_req.start <= 1'b1;
            lm_req.a     <= {34'b0, lm_rsp.p[95:0]};
            lm_req.b     <= best_den;
            state        <= S_WS_D_W;
          end else begin
            lm_req.start <= 1'b0;
          end
        end
        S_WS_D_W: begin
          lm_req.start <= 1'b0;
          if (lm_rsp.done) begin
            if (lm_rsp.p <= {34'b0, best_num, 32'b0}) begin
              lo <= mid;
            end else begin
              hi <= mid - 17'd1;
            end
            state <= S_WS_LOOP;
          end
        end
        S_FIN: begin
          if (!result_valid || !result_stall) begin
            result_valid      <= 1'b1;
            result.weight     <= weight;
            result.inside_res <= in_poly;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PZEF_ASSERT_IMPLY(a_lmul_done_waited, clk, rst, lm_rsp.done, state == S_SQ_W || state == S_CMP1_W || state == S_CMP2_W || state == S_WS_SQ_W || state == S_WS_D_W)
  `PZEF_ASSERT_IMPLY(a_search_bounds, clk, rst, state == S_WS_LOOP, lo <= hi && hi <= WEIGHT_ONE)
  `PZEF_ASSERT_NEXT(a_load_stays_idle, clk, rst, accept && item.func == FUNC_LOAD, state == S_IDLE)

endmodule

// ----- rtl/pzef_ram.sv -----
// generic single write port ram with registered read
module pzef_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/pzef_lmul.sv -----
// bit-serial shift-add long multiplier
module pzef_lmul import pzef_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  lm_req_t req,
  output lm_rsp_t rsp
);

  logic              busy;
  logic [LM_P_W-1:0] acc;
  logic [LM_P_W-1:0] ash;
  logic [LM_B_W-1:0] bsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      acc  <= '0;
      ash  <= {{LM_B_W{1'b0}}, req.a};
      bsh  <= req.b;
    end else if (busy) begin
      if (bsh == '0) begin
        busy <= 1'b0;
      end else begin
        if (bsh[0]) begin
          acc <= acc + ash;
        end
        ash <= {ash[LM_P_W-2:0], 1'b0};
        bsh <= {1'b0, bsh[LM_B_W-1:1]};
      end
    end
  end

  assign rsp.done = busy && (bsh == '0);
  assign rsp.p    = acc;

endmodule
